[rtl/core/dpm_pkg.sv]
// shared types, constants and table function for the dew point core
`timescale 1ns / 1ps
`default_nettype none

package dpm_pkg;

    // default ln table address width
    localparam int unsigned LN_TABLE_ADDR_BITS = 10;

    // unit codes
    localparam logic [7:0] UNIT_F = 8'd70;
    localparam logic [7:0] UNIT_C = 8'd67;

    // register indexes on the config port
    typedef enum logic [2:0] {
        CFG_MAX_C = 3'd0,
        CFG_MIN_C = 3'd1,
        CFG_MAX_F = 3'd2,
        CFG_MIN_F = 3'd3
    } t_cfg_idx;

    // register reset values, hundredths of a degree
    localparam logic signed [15:0] RST_MAX_C = 16'sd6000;
    localparam logic signed [15:0] RST_MIN_C = -16'sd10000;
    localparam logic signed [15:0] RST_MAX_F = 16'sd14000;
    localparam logic signed [15:0] RST_MIN_F = -16'sd14800;

    // arithmetic constants
    localparam logic [16:0] LN2_Q16    = 17'd45426;
    localparam logic signed [15:0] TC_FLOOR = -16'sd23700;
    localparam logic [26:0] MAGNUS_NUM = 27'd113180672;   // 1727 * 65536
    localparam logic [21:0] DEW_NUM    = 22'd2377000;
    localparam logic [26:0] RECIP_9    = 27'd119304648;   // ceil(2^30 / 9)
    localparam logic [27:0] RECIP_5    = 28'd214748365;   // ceil(2^30 / 5)

    // divider geometry
    localparam int unsigned DIV1_NUM_W = 42;
    localparam int unsigned DIV1_DEN_W = 23;
    localparam int unsigned DIV1_QUO_W = 29;
    localparam int unsigned DIV2_NUM_W = 50;
    localparam int unsigned DIV2_DEN_W = 36;
    localparam int unsigned DIV2_QUO_W = 17;

    typedef struct packed {
        logic reading_valid;
        logic humidity_bad;
        logic unit_bad;
        logic temperature_bad;
    } t_flags;

    // rides along the first divider
    typedef struct packed {
        t_flags             flags;
        logic               is_f;
        logic               neg;
        logic signed [20:0] ln;
    } t_pay1;

    // rides along the second divider
    typedef struct packed {
        t_flags flags;
        logic   is_f;
        logic   neg;
        logic   den_bad;
    } t_pay2;

    // shift and subtract quotient, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/2^k) in q16 via 2*atanh series in q30, elaboration only
    function automatic logic [15:0] ln_entry(input int unsigned i, input int unsigned k);
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] sum;
        logic [63:0] p;
        logic        done;
        int unsigned kk;
        if (i == 0) begin
            return 16'd0;
        end
        den  = (64'd1 << (k + 1)) + 64'(i);
        z    = udiv64(64'(i) << 30, den);
        z2   = (z * z) >> 30;
        sum  = z;
        p    = z;
        done = 1'b0;
        for (kk = 3; kk < 64; kk += 2) begin
            if (!done) begin
                p = (p * z2) >> 30;
                if (p == 64'd0) begin
                    done = 1'b1;
                end else begin
                    sum = sum + udiv64(p, 64'(kk));
                end
            end
        end
        return 16'(((sum << 1) + (64'd1 << 13)) >> 14);
    endfunction

endpackage

`default_nettype wire

[rtl/core/dew_point_magnus_core.sv]
// top level: magnus dew point pipeline with reading checks and limit registers
//
// one reading per item on the input channel (temperature, unit, humidity),
// one result item per reading on the output channel (dew point and flags).
// both channels use valid/stall; an item moves on a clock edge with valid
// high and stall low. the limit registers are written through a plain write
// port (enable, index, data); the user must write them only while the block
// is idle, and the block does not enforce this. an accepted item passes
// through 53 register stages: three front stages, a 29-stage divider for
// the magnus term, two stages, a 17-stage divider for the dew point, one
// conversion stage and the output register. throughput is one item per
// cycle unless the receiver stalls a full tail; every stage is a register
// slice, and the two dividers retire one quotient bit per stage.
// synchronous active-low reset clears all valid bits and loads the limit
// registers with their defaults; items in flight at reset are dropped.
// when the receiver stalls, the output register holds its item; the pipeline
// keeps moving while its last stage is empty, and freezes as a whole once
// the last stage and the output register are both full.
`timescale 1ns / 1ps
`default_nettype none

module dew_point_magnus_core #(
    parameter int unsigned LN_TABLE_ADDR_BITS = dpm_pkg::LN_TABLE_ADDR_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config write port
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_idx,
    input  wire logic        [15:0] i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_air_temperature,
    input  wire logic        [7:0]  i_unit_char,
    input  wire logic        [16:0] i_humidity,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed      [15:0] o_dew_point,
    output logic                    o_reading_valid,
    output logic                    o_humidity_bad,
    output logic                    o_unit_bad,
    output logic                    o_temperature_bad
);

    localparam int unsigned K  = LN_TABLE_ADDR_BITS;
    localparam int unsigned SH = 16 - K;
    localparam int unsigned N1 = dpm_pkg::DIV1_NUM_W;
    localparam int unsigned D1 = dpm_pkg::DIV1_DEN_W;
    localparam int unsigned Q1 = dpm_pkg::DIV1_QUO_W;
    localparam int unsigned N2 = dpm_pkg::DIV2_NUM_W;
    localparam int unsigned D2 = dpm_pkg::DIV2_DEN_W;
    localparam int unsigned Q2 = dpm_pkg::DIV2_QUO_W;

    // ---------------------------------------------------------------
    // limit registers
    // ---------------------------------------------------------------
    logic signed [15:0] r_max_c;
    logic signed [15:0] r_min_c;
    logic signed [15:0] r_max_f;
    logic signed [15:0] r_min_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_c <= dpm_pkg::RST_MAX_C;
            r_min_c <= dpm_pkg::RST_MIN_C;
            r_max_f <= dpm_pkg::RST_MAX_F;
            r_min_f <= dpm_pkg::RST_MIN_F;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpm_pkg::CFG_MAX_C: r_max_c <= i_cfg_data;
                dpm_pkg::CFG_MIN_C: r_min_c <= i_cfg_data;
                dpm_pkg::CFG_MAX_F: r_max_f <= i_cfg_data;
                dpm_pkg::CFG_MIN_F: r_min_f <= i_cfg_data;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: the whole pipe advances together, bubbles at the tail
    // collapse into a stalled output register
    // ---------------------------------------------------------------
    logic r_h_vld;
    logic r_out_vld;
    logic w_adv;

    assign w_adv      = !r_h_vld || !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    // ---------------------------------------------------------------
    // stage a: checks, fahrenheit offset and scale, humidity normalize
    // ---------------------------------------------------------------
    logic                 w_is_f;
    logic                 w_is_c;
    dpm_pkg::t_flags      w_flags;
    logic signed [16:0]   w_fd;
    logic signed [18:0]   w_x5;
    logic        [17:0]   w_fmag;
    logic        [4:0]    w_e;
    logic        [4:0]    w_lnsh;
    logic        [16:0]   w_norm;

    always_comb begin
        w_is_f = i_unit_char == dpm_pkg::UNIT_F;
        w_is_c = i_unit_char == dpm_pkg::UNIT_C;
        w_flags.humidity_bad = (i_humidity == 17'd0) || (i_humidity > 17'd65536);
        w_flags.unit_bad     = !w_is_f && !w_is_c;
        if (w_is_f) begin
            w_flags.temperature_bad = (i_air_temperature > r_max_f)
                                   || (i_air_temperature < r_min_f);
        end else if (w_is_c) begin
            w_flags.temperature_bad = (i_air_temperature > r_max_c)
                                   || (i_air_temperature < r_min_c);
        end else begin
            w_flags.temperature_bad = 1'b0;  // no limits for an unknown unit
        end
        w_flags.reading_valid = !w_flags.humidity_bad && !w_flags.unit_bad
                             && !w_flags.temperature_bad;
    end

    // (t - 32 deg) * 5, magnitude plus half of 9 for rounding
    always_comb begin
        w_fd   = 17'(i_air_temperature) - 17'sd3200;
        w_x5   = 19'(w_fd) * 19'sd5;
        w_fmag = w_x5[18] ? 18'(-w_x5) : 18'(w_x5);
    end

    // leading one of the humidity sets the exponent
    always_comb begin
        w_e = '0;
        for (int b = 0; b < 17; b++) begin
            if (i_humidity[b]) begin
                w_e = 5'(b);
            end
        end
        w_lnsh = 5'd16 - w_e;
        w_norm = i_humidity << w_lnsh;
    end

    logic                  r_a_vld;
    dpm_pkg::t_flags       r_a_flags;
    logic                  r_a_is_f;
    logic signed [15:0]    r_a_t;
    logic                  r_a_fneg;
    logic        [17:0]    r_a_fx;
    logic        [4:0]     r_a_lnsh;
    logic        [K-1:0]   r_a_idx;
    logic        [SH-1:0]  r_a_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_flags <= w_flags;
            r_a_is_f  <= w_is_f;
            r_a_t     <= i_air_temperature;
            r_a_fneg  <= w_x5[18];
            r_a_fx    <= w_fmag + 18'd4;
            r_a_lnsh  <= w_lnsh;
            r_a_idx   <= w_norm[15:SH];
            r_a_rem   <= w_norm[SH-1:0];
        end
    end

    // table read lands together with stage b
    logic [15:0] w_t0;
    logic [15:0] w_t1;

    dpm_ln_rom #(
        .ADDR_BITS (K)
    ) u_ln_rom (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_idx (r_a_idx),
        .o_lo  (w_t0),
        .o_hi  (w_t1)
    );

    // ---------------------------------------------------------------
    // stage b: divide by 9 via reciprocal, celsius select and floor clamp
    // ---------------------------------------------------------------
    logic        [44:0] w_p9;
    logic        [14:0] w_q9;
    logic signed [15:0] w_tc_f;
    logic signed [15:0] w_tc_raw;
    logic signed [15:0] w_tc;

    always_comb begin
        w_p9     = 45'(r_a_fx) * 45'(dpm_pkg::RECIP_9);
        w_q9     = w_p9[44:30];
        w_tc_f   = r_a_fneg ? -$signed({1'b0, w_q9}) : $signed({1'b0, w_q9});
        w_tc_raw = r_a_is_f ? w_tc_f : r_a_t;
        // keep 237.7 + tc positive near the pole
        w_tc     = (w_tc_raw < dpm_pkg::TC_FLOOR) ? dpm_pkg::TC_FLOOR : w_tc_raw;
    end

    logic                 r_b_vld;
    dpm_pkg::t_flags      r_b_flags;
    logic                 r_b_is_f;
    logic signed [15:0]   r_b_tc;
    logic                 r_b_tcneg;
    logic        [14:0]   r_b_tcmag;
    logic        [4:0]    r_b_lnsh;
    logic        [SH-1:0] r_b_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_flags <= r_a_flags;
            r_b_is_f  <= r_a_is_f;
            r_b_tc    <= w_tc;
            r_b_tcneg <= w_tc[15];
            r_b_tcmag <= w_tc[15] ? 15'(-w_tc) : w_tc[14:0];
            r_b_lnsh  <= r_a_lnsh;
            r_b_rem   <= r_a_rem;
        end
    end

    // ---------------------------------------------------------------
    // stage c: magnus numerator and denominator, interpolation product
    // ---------------------------------------------------------------
    logic signed [16:0]    w_tsum;
    logic        [15:0]    w_dt;

    assign w_tsum = 17'(r_b_tc) + 17'sd23770;
    assign w_dt   = w_t1 - w_t0;

    logic                  r_c_vld;
    dpm_pkg::t_flags       r_c_flags;
    logic                  r_c_is_f;
    logic                  r_c_neg;
    logic        [N1-1:0]  r_c_num;
    logic        [D1-1:0]  r_c_den;
    logic        [15+SH:0] r_c_prod;
    logic        [15:0]    r_c_t0;
    logic        [4:0]     r_c_lnsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_flags <= r_b_flags;
            r_c_is_f  <= r_b_is_f;
            r_c_neg   <= r_b_tcneg;
            r_c_num   <= N1'(r_b_tcmag) * N1'(dpm_pkg::MAGNUS_NUM);
            r_c_den   <= D1'(w_tsum[15:0]) * D1'(100);
            r_c_prod  <= (16+SH)'(w_dt) * (16+SH)'(r_b_rem);
            r_c_t0    <= w_t0;
            r_c_lnsh  <= r_b_lnsh;
        end
    end

    // ---------------------------------------------------------------
    // stage d: ln(rh) finish, rounding bias, first divider
    // ---------------------------------------------------------------
    logic        [15+SH:0] w_ip;
    logic        [15:0]    w_interp;
    logic signed [20:0]    w_ln;
    dpm_pkg::t_pay1        w_pay1_in;
    dpm_pkg::t_pay1        w_pay1_out;
    logic                  w_d1_vld;
    logic        [Q1-1:0]  w_q1;

    always_comb begin
        w_ip     = r_c_prod + (16+SH)'(1 << (SH - 1));
        w_interp = w_ip[15+SH:SH];
        // ln2 times the normalizing shift comes off the table value
        w_ln     = 21'(r_c_t0) + 21'(w_interp)
                 - 21'(r_c_lnsh) * 21'(dpm_pkg::LN2_Q16);
        w_pay1_in.flags = r_c_flags;
        w_pay1_in.is_f  = r_c_is_f;
        w_pay1_in.neg   = r_c_neg;
        w_pay1_in.ln    = w_ln;
    end

    dpm_div #(
        .NUM_W (N1),
        .DEN_W (D1),
        .QUO_W (Q1),
        .PAY_W ($bits(dpm_pkg::t_pay1))
    ) u_div_magnus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_c_vld),
        .i_num   (r_c_num + N1'(r_c_den >> 1)),
        .i_den   (r_c_den),
        .i_pay   (w_pay1_in),
        .o_vld   (w_d1_vld),
        .o_quo   (w_q1),
        .o_pay   (w_pay1_out)
    );

    // ---------------------------------------------------------------
    // stage e: signed magnus term plus ln gives gamma
    // ---------------------------------------------------------------
    logic signed [29:0] w_qs;
    logic signed [29:0] w_g;

    always_comb begin
        w_qs = w_pay1_out.neg ? -$signed({1'b0, w_q1}) : $signed({1'b0, w_q1});
        w_g  = w_qs + 30'(w_pay1_out.ln);
    end

    logic                r_e_vld;
    dpm_pkg::t_flags     r_e_flags;
    logic                r_e_is_f;
    logic signed [29:0]  r_e_g;
    logic                r_e_gneg;
    logic        [28:0]  r_e_gmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_flags <= w_pay1_out.flags;
            r_e_is_f  <= w_pay1_out.is_f;
            r_e_g     <= w_g;
            r_e_gneg  <= w_g[29];
            r_e_gmag  <= w_g[29] ? 29'(-w_g) : w_g[28:0];
        end
    end

    // ---------------------------------------------------------------
    // stage f: dew point numerator and denominator
    // ---------------------------------------------------------------
    logic signed [37:0] w_d2;

    assign w_d2 = 38'sd113180672 - 38'(r_e_g) * 38'sd100;

    logic               r_f_vld;
    dpm_pkg::t_flags    r_f_flags;
    logic               r_f_is_f;
    logic               r_f_neg;
    logic      [N2-1:0] r_f_num;
    logic      [D2-1:0] r_f_den;
    logic               r_f_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_flags <= r_e_flags;
            r_f_is_f  <= r_e_is_f;
            r_f_neg   <= r_e_gneg;
            r_f_num   <= N2'(r_e_gmag) * N2'(dpm_pkg::DEW_NUM);
            r_f_den   <= w_d2[D2-1:0];
            r_f_bad   <= w_d2[37] || (w_d2 == 38'sd0);
        end
    end

    // ---------------------------------------------------------------
    // stage g: second divider
    // ---------------------------------------------------------------
    dpm_pkg::t_pay2 w_pay2_in;
    dpm_pkg::t_pay2 w_pay2_out;
    logic           w_d2_vld;
    logic [Q2-1:0]  w_q2;

    always_comb begin
        w_pay2_in.flags   = r_f_flags;
        w_pay2_in.is_f    = r_f_is_f;
        w_pay2_in.neg     = r_f_neg;
        w_pay2_in.den_bad = r_f_bad;
    end

    dpm_div #(
        .NUM_W (N2),
        .DEN_W (D2),
        .QUO_W (Q2),
        .PAY_W ($bits(dpm_pkg::t_pay2))
    ) u_div_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_f_vld),
        .i_num   (r_f_num + N2'(r_f_den >> 1)),
        .i_den   (r_f_den),
        .i_pay   (w_pay2_in),
        .o_vld   (w_d2_vld),
        .o_quo   (w_q2),
        .o_pay   (w_pay2_out)
    );

    // ---------------------------------------------------------------
    // stage h: celsius dew point, scale by 9 for the fahrenheit path
    // ---------------------------------------------------------------
    logic signed [17:0] w_dc;
    logic        [16:0] w_dcmag;

    always_comb begin
        if (w_pay2_out.den_bad) begin
            w_dc = 18'sd32767;
        end else if (w_pay2_out.neg) begin
            w_dc = -$signed({1'b0, w_q2});
        end else begin
            w_dc = $signed({1'b0, w_q2});
        end
        w_dcmag = w_dc[17] ? 17'(-w_dc) : w_dc[16:0];
    end

    dpm_pkg::t_flags    r_h_flags;
    logic               r_h_is_f;
    logic signed [17:0] r_h_dc;
    logic               r_h_neg;
    logic        [20:0] r_h_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_adv) begin
            r_h_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_flags <= w_pay2_out.flags;
            r_h_is_f  <= w_pay2_out.is_f;
            r_h_dc    <= w_dc;
            r_h_neg   <= w_dc[17];
            r_h_x     <= 21'(w_dcmag) * 21'd9 + 21'd2;
        end
    end

    // ---------------------------------------------------------------
    // output stage: divide by 5, offset, saturate, zero invalid readings
    // ---------------------------------------------------------------
    logic        [48:0] w_p5;
    logic        [18:0] w_q5;
    logic signed [20:0] w_fv;
    logic signed [20:0] w_res;
    logic signed [15:0] w_sat;

    always_comb begin
        w_p5  = 49'(r_h_x) * 49'(dpm_pkg::RECIP_5);
        w_q5  = w_p5[48:30];
        w_fv  = (r_h_neg ? -$signed({2'b0, w_q5}) : $signed({2'b0, w_q5})) + 21'sd3200;
        w_res = r_h_is_f ? w_fv : 21'(r_h_dc);
        if (w_res > 21'sd32767) begin
            w_sat = 16'sd32767;
        end else if (w_res < -21'sd32768) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_res[15:0];
        end
        if (!r_h_flags.reading_valid) begin
            w_sat = '0;
        end
    end

    dpm_pkg::t_flags    r_out_flags;
    logic signed [15:0] r_out_dew;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || !i_out_stall) begin
            r_out_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_h_vld && (!r_out_vld || !i_out_stall)) begin
            r_out_flags <= r_h_flags;
            r_out_dew   <= w_sat;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_dew_point       = r_out_dew;
    assign o_reading_valid   = r_out_flags.reading_valid;
    assign o_humidity_bad    = r_out_flags.humidity_bad;
    assign o_unit_bad        = r_out_flags.unit_bad;
    assign o_temperature_bad = r_out_flags.temperature_bad;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reading_valid |-> o_dew_point == 16'sd0)
        else $error("invalid reading with nonzero dew point");

    a_valid_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_reading_valid
            == !(o_humidity_bad || o_unit_bad || o_temperature_bad))
        else $error("reading valid disagrees with check flags");

    a_unit_no_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unit_bad |-> !o_temperature_bad)
        else $error("temperature flagged for an unknown unit");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_h_vld && r_out_vld && i_out_stall)
        else $error("input stalled while the tail had room");

    a_freeze_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_h_vld) && $stable(r_h_dc))
        else $error("tail stage moved while frozen");

endmodule

`default_nettype wire

[rtl/core/dpm_ln_rom.sv]
// constant ln(1+f) table with two registered read ports (entry and next entry)
`timescale 1ns / 1ps
`default_nettype none

module dpm_ln_rom #(
    parameter int unsigned ADDR_BITS = dpm_pkg::LN_TABLE_ADDR_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [ADDR_BITS-1:0] i_idx,
    output logic      [15:0]          o_lo,
    output logic      [15:0]          o_hi
);

    localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

    logic [15:0]        w_tab [DEPTH];
    logic [ADDR_BITS:0] w_addr;
    logic [15:0]        r_lo;
    logic [15:0]        r_hi;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tab
        localparam logic [15:0] ENTRY = dpm_pkg::ln_entry(gi, ADDR_BITS);
        assign w_tab[gi] = ENTRY;
    end

    assign w_addr = {1'b0, i_idx};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= w_tab[w_addr];
            r_hi <= w_tab[w_addr + (ADDR_BITS+1)'(1)];
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

`default_nettype wire

[rtl/core/dpm_div.sv]
// pipelined restoring divider, one quotient bit per stage, payload alongside
`timescale 1ns / 1ps
`default_nettype none

module dpm_div #(
    parameter int unsigned NUM_W = dpm_pkg::DIV1_NUM_W,
    parameter int unsigned DEN_W = dpm_pkg::DIV1_DEN_W,
    parameter int unsigned QUO_W = dpm_pkg::DIV1_QUO_W,
    parameter int unsigned PAY_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [PAY_W-1:0] i_pay,
    output logic                  o_vld,
    output logic      [QUO_W-1:0] o_quo,
    output logic      [PAY_W-1:0] o_pay
);

    localparam int unsigned W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic             r_vld [QUO_W];
    logic [W-1:0]     r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [PAY_W-1:0] r_pay [QUO_W];

    logic             w_vld_in [QUO_W];
    logic [W-1:0]     w_rem_in [QUO_W];
    logic [DEN_W-1:0] w_den_in [QUO_W];
    logic [QUO_W-1:0] w_quo_in [QUO_W];
    logic [PAY_W-1:0] w_pay_in [QUO_W];

    assign w_vld_in[0] = i_vld;
    assign w_rem_in[0] = W'(i_num);
    assign w_den_in[0] = i_den;
    assign w_quo_in[0] = '0;
    assign w_pay_in[0] = i_pay;

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int unsigned BIT = QUO_W - 1 - s;

        logic [W-1:0]     w_shd;
        logic [W:0]       w_diff;
        logic [W-1:0]     n_rem;
        logic [QUO_W-1:0] n_quo;

        if (s > 0) begin : g_link
            assign w_vld_in[s] = r_vld[s-1];
            assign w_rem_in[s] = r_rem[s-1];
            assign w_den_in[s] = r_den[s-1];
            assign w_quo_in[s] = r_quo[s-1];
            assign w_pay_in[s] = r_pay[s-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        always_comb begin
            w_shd  = W'(w_den_in[s]) << BIT;
            w_diff = {1'b0, w_rem_in[s]} - {1'b0, w_shd};
            n_quo  = w_quo_in[s];
            if (!w_diff[W]) begin
                n_rem      = w_diff[W-1:0];
                n_quo[BIT] = 1'b1;
            end else begin
                n_rem = w_rem_in[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= w_den_in[s];
                r_quo[s] <= n_quo;
                r_pay[s] <= w_pay_in[s];
            end
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];
    assign o_pay = r_pay[QUO_W-1];

endmodule

`default_nettype wire

[tb/tb_dew_point_magnus_core.sv]
// testbench for the magnus dew point core: directed and random readings checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_dew_point_magnus_core;

    localparam int K_BITS      = dpm_pkg::LN_TABLE_ADDR_BITS;
    localparam int LATENCY     = 53;
    localparam int WATCHDOG    = 20000;

    // one result item as the block reports it
    typedef struct {
        logic signed [15:0] dew;
        logic               ok;
        logic               hum_bad;
        logic               unit_bad;
        logic               temp_bad;
    } t_dew_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic        [2:0]  i_cfg_idx;
    logic        [15:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_air_temperature;
    logic        [7:0]  i_unit_char;
    logic        [16:0] i_humidity;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_dew_point;
    logic               o_reading_valid;
    logic               o_humidity_bad;
    logic               o_unit_bad;
    logic               o_temperature_bad;

    dew_point_magnus_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_air_temperature (i_air_temperature),
        .i_unit_char       (i_unit_char),
        .i_humidity        (i_humidity),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_dew_point       (o_dew_point),
        .o_reading_valid   (o_reading_valid),
        .o_humidity_bad    (o_humidity_bad),
        .o_unit_bad        (o_unit_bad),
        .o_temperature_bad (o_temperature_bad)
    );

    // predictor copy of the limit registers
    logic signed [15:0] lim_max_c;
    logic signed [15:0] lim_min_c;
    logic signed [15:0] lim_max_f;
    logic signed [15:0] lim_min_f;

    logic [15:0]  ln_tab [0:(1 << K_BITS)];
    t_dew_result  pending_dew[$];
    int           errors;
    int           n_sent;
    int           n_checked;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // rounds to nearest, ties away from zero
    function automatic longint round_div(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q   = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    // ln(1 + i/2^k) in q16 from the atanh series in q30
    function automatic logic [15:0] ln_table_entry(input int unsigned i);
        longint unsigned den;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned sum;
        longint unsigned p;
        if (i == 0) return 16'd0;
        den = (64'd1 << (K_BITS + 1)) + i;
        z   = (64'(i) << 30) / den;
        z2  = (z * z) >> 30;
        sum = z;
        p   = z;
        for (int k = 3; k < 64; k += 2) begin
            p = (p * z2) >> 30;
            if (p == 0) break;
            sum += p / k;
        end
        return 16'((2 * sum + (64'd1 << 13)) >> 14);
    endfunction

    // natural log of a q1.16 humidity, q16
    function automatic longint ln_humidity(input logic [16:0] h);
        int          e;
        int unsigned sh;
        int unsigned m;
        int unsigned frac;
        int unsigned idx;
        int unsigned rem;
        longint      t0;
        longint      t1;
        sh = 16 - K_BITS;
        e  = 16;
        while (e > 0 && h[e] == 1'b0) e--;
        m    = (32'(h) << (16 - e)) & 32'h1FFFF;
        frac = m & 32'hFFFF;
        idx  = frac >> sh;
        rem  = frac & ((1 << sh) - 1);
        t0   = ln_tab[idx];
        t1   = ln_tab[idx + 1];
        t0   = t0 + (((t1 - t0) * rem + (1 << (sh - 1))) >> sh);
        return t0 - longint'(16 - e) * 45426;
    endfunction

    function automatic t_dew_result predict_dew(input logic signed [15:0] t,
                                                input logic [7:0] unit,
                                                input logic [16:0] h);
        t_dew_result r;
        logic   is_f;
        logic   is_c;
        longint tc;
        longint g;
        longint d;
        longint dew;
        is_f       = (unit == dpm_pkg::UNIT_F);
        is_c       = (unit == dpm_pkg::UNIT_C);
        r.hum_bad  = (h == 0) || (h > 17'd65536);
        r.unit_bad = !is_f && !is_c;
        r.temp_bad = is_f ? (t > lim_max_f || t < lim_min_f)
                   : is_c ? (t > lim_max_c || t < lim_min_c) : 1'b0;
        r.ok       = !r.hum_bad && !r.unit_bad && !r.temp_bad;
        dew        = 0;
        if (r.ok) begin
            tc = is_f ? round_div((longint'(t) - 3200) * 5, 9) : longint'(t);
            if (tc < -23700) tc = -23700;
            g = round_div(1727 * tc * 65536, 100 * (23770 + tc)) + ln_humidity(h);
            d = 113180672 - 100 * g;
            dew = (d <= 0) ? 32767 : round_div(2377000 * g, d);
            if (is_f) dew = round_div(dew * 9, 5) + 3200;
            if (dew > 32767) dew = 32767;
            if (dew < -32768) dew = -32768;
        end
        r.dew = 16'(dew);
        return r;
    endfunction

    // result checker and receiver idling
    always @(posedge i_clk) begin
        t_dew_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_checked++;
                if (pending_dew.size() == 0) begin
                    $display("%0t: result item with no reading pending", $time);
                    errors++;
                end else begin
                    want = pending_dew.pop_front();
                    if (o_dew_point !== want.dew || o_reading_valid !== want.ok ||
                        o_humidity_bad !== want.hum_bad || o_unit_bad !== want.unit_bad ||
                        o_temperature_bad !== want.temp_bad) begin
                        $display("%0t: mismatch expected dew=%0d v=%b h=%b u=%b t=%b",
                                 $time, want.dew, want.ok, want.hum_bad,
                                 want.unit_bad, want.temp_bad);
                        $display("%0t:          actual   dew=%0d v=%b h=%b u=%b t=%b",
                                 $time, o_dew_point, o_reading_valid, o_humidity_bad,
                                 o_unit_bad, o_temperature_bad);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sends one reading and records its expected result at acceptance;
    // valid stays high after acceptance until the next idle or drain
    task automatic send_reading(input logic signed [15:0] t, input logic [7:0] unit,
                                input logic [16:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_air_temperature <= t;
        i_unit_char       <= unit;
        i_humidity        <= h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_dew.insert(pending_dew.size(), predict_dew(t, unit, h));
        n_sent++;
    endtask

    // waits out every pending result and the pipeline tail
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_dew.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_limit(input dpm_pkg::t_cfg_idx idx, input logic signed [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dpm_pkg::CFG_MAX_C: lim_max_c = v;
            dpm_pkg::CFG_MIN_C: lim_min_c = v;
            dpm_pkg::CFG_MAX_F: lim_max_f = v;
            dpm_pkg::CFG_MIN_F: lim_min_f = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_unit();
        int sel;
        sel = $urandom_range(9);
        return (sel < 4) ? dpm_pkg::UNIT_C : (sel < 8) ? dpm_pkg::UNIT_F : 8'($urandom);
    endfunction

    function automatic logic [16:0] rand_humidity();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0) return 17'd0;
        if (sel == 1) return 17'($urandom_range(131071, 65537));
        if (sel == 2) return 17'd65536;
        if (sel < 6)  return 17'($urandom_range(255, 1));
        return 17'($urandom_range(65536, 1));
    endfunction

    // extremes of every field, both units and each check
    task automatic test_directed();
        send_reading(16'sd2000, dpm_pkg::UNIT_C, 17'd32768);
        send_reading(16'sd2000, dpm_pkg::UNIT_C, 17'd65536);
        send_reading(16'sd2000, dpm_pkg::UNIT_C, 17'd1);
        send_reading(16'sd2000, dpm_pkg::UNIT_C, 17'd0);
        send_reading(16'sd2000, dpm_pkg::UNIT_C, 17'd65537);
        send_reading(16'sd2000, dpm_pkg::UNIT_C, 17'h1FFFF);
        send_reading(16'sd6800, dpm_pkg::UNIT_F, 17'd50000);
        send_reading(16'sd2000, 8'h00, 17'd40000);
        send_reading(16'sd2000, 8'hFF, 17'd40000);
        send_reading(16'sd2000, 8'd99, 17'd0);
        send_reading(16'sd6000, dpm_pkg::UNIT_C, 17'd65536);
        send_reading(16'sd6001, dpm_pkg::UNIT_C, 17'd65536);
        send_reading(-16'sd10000, dpm_pkg::UNIT_C, 17'd1);
        send_reading(-16'sd10001, dpm_pkg::UNIT_C, 17'd100);
        send_reading(16'sd14000, dpm_pkg::UNIT_F, 17'd65536);
        send_reading(16'sd14001, dpm_pkg::UNIT_F, 17'd65536);
        send_reading(-16'sd14800, dpm_pkg::UNIT_F, 17'd3);
        send_reading(-16'sd14801, dpm_pkg::UNIT_F, 17'd3);
        send_reading(16'sh7FFF, dpm_pkg::UNIT_C, 17'd20000);
        send_reading(16'sh8000, dpm_pkg::UNIT_F, 17'd20000);
        drain_pipeline();
    endtask

    // wide limits so the pole clamp and saturation are reached
    task automatic test_wide_limits();
        write_limit(dpm_pkg::CFG_MAX_C, 16'sh7FFF);
        write_limit(dpm_pkg::CFG_MIN_C, 16'sh8000);
        write_limit(dpm_pkg::CFG_MAX_F, 16'sh7FFF);
        write_limit(dpm_pkg::CFG_MIN_F, 16'sh8000);
        send_reading(16'sh8000, dpm_pkg::UNIT_C, 17'd1);
        send_reading(-16'sd23701, dpm_pkg::UNIT_C, 17'd65536);
        send_reading(16'sh8000, dpm_pkg::UNIT_F, 17'd1);
        send_reading(16'sh7FFF, dpm_pkg::UNIT_C, 17'd65536);
        send_reading(16'sh7FFF, dpm_pkg::UNIT_F, 17'd65536);
        repeat (60) send_reading(16'($urandom), rand_unit(), rand_humidity());
        drain_pipeline();
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            send_reading(16'($urandom), rand_unit(), rand_humidity());
            // sender holds off until the pipeline is empty
            if (n == count / 2) begin
                i_in_valid <= 1'b0;
                while (pending_dew.size() != 0) @(posedge i_clk);
            end
        end
        drain_pipeline();
    endtask

    // random readings under several limit settings and idling patterns
    task automatic test_random_readings();
        write_limit(dpm_pkg::CFG_MAX_C, dpm_pkg::RST_MAX_C);
        write_limit(dpm_pkg::CFG_MIN_C, dpm_pkg::RST_MIN_C);
        write_limit(dpm_pkg::CFG_MAX_F, dpm_pkg::RST_MAX_F);
        write_limit(dpm_pkg::CFG_MIN_F, dpm_pkg::RST_MIN_F);
        send_idle_pct = 11;
        recv_idle_pct = 72;
        random_phase(150);
        // narrow and inverted limits
        write_limit(dpm_pkg::CFG_MAX_C, 16'sd0);
        write_limit(dpm_pkg::CFG_MIN_C, 16'sd0);
        write_limit(dpm_pkg::CFG_MAX_F, 16'sh8000);
        write_limit(dpm_pkg::CFG_MIN_F, 16'sh7FFF);
        send_idle_pct = 72;
        recv_idle_pct = 11;
        random_phase(150);
        write_limit(dpm_pkg::CFG_MAX_C, 16'sd4000);
        write_limit(dpm_pkg::CFG_MIN_C, -16'sd4000);
        write_limit(dpm_pkg::CFG_MAX_F, 16'sd10000);
        write_limit(dpm_pkg::CFG_MIN_F, -16'sd2000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = dpm_pkg::CFG_MAX_C;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_air_temperature = '0;
        i_unit_char       = '0;
        i_humidity        = '0;
        i_out_stall       = 1'b0;
        errors            = 0;
        n_sent            = 0;
        n_checked         = 0;
        idle_cycles       = 0;
        send_idle_pct     = 11;
        recv_idle_pct     = 72;
        lim_max_c         = dpm_pkg::RST_MAX_C;
        lim_min_c         = dpm_pkg::RST_MIN_C;
        lim_max_f         = dpm_pkg::RST_MAX_F;
        lim_min_f         = dpm_pkg::RST_MIN_F;
        for (int i = 0; i <= (1 << K_BITS); i++) ln_tab[i] = ln_table_entry(i);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_wide_limits();
        test_random_readings();
        $display("covered %0d readings, %0d results checked, over four limit settings",
                 n_sent, n_checked);
        $display("and three sender/receiver idling patterns");
        if (errors == 0 && pending_dew.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
